@@ sv/npa_pkg.sv @@
// ---------------------------------------------------------------------------
// npa_pkg
// Shared types and codes for the nat source port allocator.
// ---------------------------------------------------------------------------
package npa_pkg;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SRC_ADDR  = 3'd0;
  localparam cfg_idx_t CFG_PORT_LOW  = 3'd1;
  localparam cfg_idx_t CFG_PORT_HIGH = 3'd2;
  localparam cfg_idx_t CFG_DST_ADDR  = 3'd3;
  localparam cfg_idx_t CFG_DST_PORT  = 3'd4;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [15:0] PORT_LOW_RST  = 16'd1024;
  localparam logic [15:0] PORT_HIGH_RST = 16'hffff;

  typedef struct packed {
    logic        mode;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] new_src_addr;
    logic [15:0] new_src_port;
    logic [31:0] new_dst_addr;
    logic [15:0] new_dst_port;
    logic        overflow;
  } out_word_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
  } cfg_t;

  // fresh port counter reload request from a register write
  typedef struct packed {
    logic        reload;
    logic [15:0] value;
  } fresh_load_t;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

endpackage

@@ sv/npa_cfg.sv @@
// ---------------------------------------------------------------------------
// npa_cfg
// Pattern and pool registers, plus the fresh port reload on any register write.
// ---------------------------------------------------------------------------
module npa_cfg
  import npa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_wdata,
  output cfg_t        cfg,
  output fresh_load_t fresh_load
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt          = cfg_r;
    fresh_load.reload = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_ADDR: begin
          cfg_nxt.src_addr  = cfg_wdata;
          fresh_load.reload = 1'b1;
        end
        CFG_PORT_LOW: begin
          cfg_nxt.port_low  = cfg_wdata[15:0];
          fresh_load.reload = 1'b1;
        end
        CFG_PORT_HIGH: begin
          cfg_nxt.port_high = cfg_wdata[15:0];
          fresh_load.reload = 1'b1;
        end
        CFG_DST_ADDR: begin
          cfg_nxt.dst_addr  = cfg_wdata;
          fresh_load.reload = 1'b1;
        end
        CFG_DST_PORT: begin
          cfg_nxt.dst_port  = cfg_wdata[15:0];
          fresh_load.reload = 1'b1;
        end
        default: begin
          fresh_load.reload = 1'b0;
        end
      endcase
    end
    // counter restarts at the low bound as it stands after this write
    fresh_load.value = cfg_nxt.port_low;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_addr  <= '0;
      cfg_r.port_low  <= PORT_LOW_RST;
      cfg_r.port_high <= PORT_HIGH_RST;
      cfg_r.dst_addr  <= '0;
      cfg_r.dst_port  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/npa_stack.sv @@
// ---------------------------------------------------------------------------
// npa_stack
// Release stack storage: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module npa_stack
  import npa_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/nat_port_pattern_allocator.sv @@
// ---------------------------------------------------------------------------
// nat_port_pattern_allocator
// Source port allocator with tuple rewrite: allocate pops a released port
// (LIFO) or the next fresh port; a matching release pushes its port if not full.
// ---------------------------------------------------------------------------
//  channel  ports                        direction  word
//  input    in_valid/in_ready/in_word    in         in_word_t
//  result   out_valid/out_ready/out_word out        out_word_t
//  config   cfg_we/cfg_index/cfg_wdata   in         32-bit register write
//
//  each word is accepted (stack access, counter update), then in the
//  emit state its result, with the registered stack read, is loaded into
//  the output register; no new word is taken before that. a stalled
//  result holds the block in its emit state until out_ready. reset is
//  synchronous; the stack needs no clearing as only pushed entries pop.
// ---------------------------------------------------------------------------
module nat_port_pattern_allocator
  import npa_pkg::*;
#(
  parameter int RELEASE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = (RELEASE_DEPTH > 1) ? $clog2(RELEASE_DEPTH) : 1;
  localparam int CW = $clog2(RELEASE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(RELEASE_DEPTH);

  cfg_t        cfg;
  fresh_load_t fresh_load;

  npa_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cfg        (cfg),
    .fresh_load (fresh_load)
  );

  state_t         state_r, state_nxt;
  logic [16:0]    fresh_next_r, fresh_next_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  in_word_t       item_r;
  logic           alloc_r, ok_r, ovf_r, from_stack_r;
  logic [15:0]    fresh_port_r;
  logic           out_valid_r;
  out_word_t      out_word_r;

  logic           in_fire, load_out;
  logic           is_alloc, match, do_pop, do_fresh, do_push, full;
  logic [CW-1:0]  count_dec;
  logic           stack_we, stack_re;
  logic [AW-1:0]  stack_waddr, stack_raddr;
  logic [15:0]    stack_rdata;
  logic [15:0]    port_sel;
  out_word_t      result;

  assign in_fire  = in_valid && in_ready;
  assign is_alloc = (in_word.mode == MODE_ALLOC);
  assign full     = (count_r == FULL_COUNT);
  assign count_dec = count_r - CW'(1);

  assign match = ((cfg.src_addr == '0) || (cfg.src_addr == in_word.src_addr))
              && ((cfg.dst_addr == '0) || (cfg.dst_addr == in_word.dst_addr))
              && ((cfg.dst_port == '0) || (cfg.dst_port == in_word.dst_port))
              && (cfg.port_low <= in_word.src_port)
              && (in_word.src_port <= cfg.port_high);

  assign do_pop   = in_fire && is_alloc && (count_r != '0);
  assign do_fresh = in_fire && is_alloc && (count_r == '0)
                 && (fresh_next_r <= {1'b0, cfg.port_high});
  assign do_push  = in_fire && !is_alloc && match && !full;

  assign stack_we    = do_push;
  assign stack_waddr = count_r[AW-1:0];
  assign stack_re    = do_pop;
  assign stack_raddr = count_dec[AW-1:0];

  npa_stack #(
    .DEPTH (RELEASE_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (in_word.src_port),
    .re    (stack_re),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_EMIT: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    fresh_next_nxt = fresh_next_r;
    if (fresh_load.reload) begin
      fresh_next_nxt = {1'b0, fresh_load.value};
    end else if (do_fresh) begin
      fresh_next_nxt = fresh_next_r + 17'd1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_pop) begin
      count_nxt = count_dec;
    end else if (do_push) begin
      count_nxt = count_r + CW'(1);
    end
  end

  // popped port arrives from the stack in the cycle after accept
  assign port_sel = from_stack_r ? stack_rdata : fresh_port_r;

  always_comb begin
    result          = '0;
    result.ok       = ok_r;
    result.overflow = ovf_r;
    if (alloc_r && ok_r) begin
      result.new_src_addr = (cfg.src_addr != '0) ? cfg.src_addr : item_r.src_addr;
      result.new_src_port = (port_sel != '0) ? port_sel : item_r.src_port;
      result.new_dst_addr = (cfg.dst_addr != '0) ? cfg.dst_addr : item_r.dst_addr;
      result.new_dst_port = (cfg.dst_port != '0) ? cfg.dst_port : item_r.dst_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fresh_next_r <= {1'b0, PORT_LOW_RST};
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fresh_next_r <= fresh_next_nxt;
      count_r      <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r       <= in_word;
      alloc_r      <= is_alloc;
      ok_r         <= is_alloc ? ((count_r != '0) || (fresh_next_r <= {1'b0, cfg.port_high}))
                               : match;
      ovf_r        <= !is_alloc && match && full;
      from_stack_r <= is_alloc && (count_r != '0);
      fresh_port_r <= fresh_next_r[15:0];
    end
    if (load_out) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("release count above stack depth");

  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(stack_we && stack_re))
    else $error("push and pop in the same cycle");

  a_accept_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EMIT))
    else $error("accepted word not followed by emit");

  // an overflow word is a matching release, so its rewrite fields are zero
  a_ovf_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_word_r.overflow
                     || (out_word_r.ok && (out_word_r.new_src_port == '0))))
    else $error("overflow flagged without a matching release");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (count_r == $past(count_dec)))
    else $error("pop did not decrement the release count");

endmodule
